@@ sv/dgp_pkg.sv @@
// Package for the decimal digit glyph placer.
// Holds the request and record structs, the queue descriptor, the sizing constants and
// the register index codes. It depends on nothing else.
package dgp_pkg;

  localparam int MAX_DIGITS  = 7;
  localparam int CELL_WIDTH  = 8;
  localparam int DIGIT_LIMIT = 10 ** MAX_DIGITS - 1;

  localparam int MAG_W = $clog2(DIGIT_LIMIT + 1);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int POS_W = $clog2(MAX_DIGITS);
  localparam int N_W   = $clog2(MAX_DIGITS + 2);

  // The quotient by ten is (v * DIV10_MUL) >> DIV10_SHIFT. It is exact for any 32-bit v.
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  localparam logic [3:0] MINUS_GLYPH    = 4'd10;
  localparam logic [5:0] XOR_PLANES_MIN = 6'd9;

  localparam logic [5:0] GLYPH_HEIGHT_RST  = 6'd12;
  localparam logic [5:0] COLOUR_PLANES_RST = 6'd1;

  typedef enum logic [0:0] {
    CFG_GLYPH_HEIGHT  = 1'b0,
    CFG_COLOUR_PLANES = 1'b1
  } dgp_cfg_idx_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } dgp_front_state_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [11:0]        x_pos;
    logic [11:0]        y_pos;
    logic               fill;
  } dgp_in_t;

  typedef struct packed {
    logic [3:0]         glyph;
    logic [6:0]         src_x;
    logic signed [13:0] dest_x;
    logic [11:0]        dest_y;
    logic [12:0]        dest_y_bottom;
    logic               xor_mode;
    logic               last;
  } dgp_out_t;

  // One converted number, digits least significant first.
  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [CNT_W-1:0]           ndig;
    logic                       neg;
    logic [11:0]                x_pos;
    logic [11:0]                y_pos;
    logic                       fill;
  } dgp_desc_t;

endpackage

@@ sv/dgp_front.sv @@
// Front end of the glyph placer: takes a request, clamps it and converts the magnitude
// to decimal one digit per cycle, then hands a descriptor to the queue.
// Depends on dgp_pkg.
module dgp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dgp_pkg::dgp_in_t  in_data,
  output logic              busy,
  input  logic              q_full,
  output logic              q_push,
  output dgp_pkg::dgp_desc_t q_desc
);
  import dgp_pkg::*;

  dgp_front_state_t state_r, state_nxt;

  logic [MAG_W-1:0]           mag_r, mag_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [MAX_DIGITS-1:0][3:0] digits_r, digits_nxt;
  logic                       neg_r, neg_nxt;
  logic [11:0]                x_r, x_nxt;
  logic [11:0]                y_r, y_nxt;
  logic                       fill_r, fill_nxt;

  logic [31:0]        mag32;
  logic               too_big;
  logic [MAG_W+31:0]  prod;
  logic [MAG_W-1:0]   quot;
  logic [MAG_W-1:0]   rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    cnt_r    <= cnt_nxt;
    digits_r <= digits_nxt;
    neg_r    <= neg_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    fill_r   <= fill_nxt;
  end

  assign mag32   = in_data.value[31] ? (32'd0 - in_data.value) : in_data.value;
  assign too_big = mag32 > 32'(DIGIT_LIMIT);

  assign prod = mag_r * DIV10_MUL;
  assign quot = MAG_W'(prod >> DIV10_SHIFT);
  assign rem  = mag_r - ((quot << 3) + (quot << 1));

  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    cnt_nxt    = cnt_r;
    digits_nxt = digits_r;
    neg_nxt    = neg_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    fill_nxt   = fill_r;
    q_push     = 1'b0;
    case (state_r)
      FR_IDLE: begin
        if (start) begin
          // Magnitudes past the field width, the most negative value too, show as zero.
          mag_nxt   = too_big ? '0 : mag32[MAG_W-1:0];
          neg_nxt   = in_data.value[31] & ~too_big;
          x_nxt     = in_data.x_pos;
          y_nxt     = in_data.y_pos;
          fill_nxt  = in_data.fill;
          cnt_nxt   = '0;
          state_nxt = FR_CONV;
        end
      end
      FR_CONV: begin
        digits_nxt[cnt_r[POS_W-1:0]] = rem[3:0];
        cnt_nxt = cnt_r + 1'b1;
        mag_nxt = quot;
        if (quot == '0) begin
          state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  assign busy = (state_r != FR_IDLE);

  always_comb begin
    q_desc.digits = digits_r;
    q_desc.ndig   = cnt_r;
    q_desc.neg    = neg_r;
    q_desc.x_pos  = x_r;
    q_desc.y_pos  = y_r;
    q_desc.fill   = fill_r;
  end

endmodule

@@ sv/dgp_queue.sv @@
// Two-entry descriptor queue between the converter and the record emitter.
// Depends on dgp_pkg.
module dgp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dgp_pkg::dgp_desc_t  wr_desc,
  input  logic                pop,
  output dgp_pkg::dgp_desc_t  rd_desc,
  output logic                full,
  output logic                empty
);
  import dgp_pkg::*;

  dgp_desc_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_desc;
    end
  end

  assign rd_desc = mem_r[rptr_r];

endmodule

@@ sv/dgp_back.sv @@
// Back end of the glyph placer: takes one descriptor off the queue and emits one
// placement record per cycle, minus sign first, into a registered output.
// Depends on dgp_pkg.
module dgp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  dgp_pkg::dgp_desc_t q_desc,
  output logic               q_pop,
  input  logic [5:0]         glyph_height,
  input  logic [5:0]         colour_planes,
  output logic               out_valid,
  output dgp_pkg::dgp_out_t  out_data
);
  import dgp_pkg::*;

  logic                       active_r, active_nxt;
  logic                       minus_r, minus_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [MAX_DIGITS-1:0][3:0] digits_r, digits_nxt;
  logic [13:0]                dx_r, dx_nxt;
  logic [11:0]                y_r, y_nxt;
  logic                       ovalid_r, ovalid_nxt;
  dgp_out_t                   odata_r, odata_nxt;

  logic [N_W-1:0] nchar;
  logic [13:0]    offset;
  logic [3:0]     glyph;
  logic           is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    minus_r  <= minus_nxt;
    pos_r    <= pos_nxt;
    digits_r <= digits_nxt;
    dx_r     <= dx_nxt;
    y_r      <= y_nxt;
    odata_r  <= odata_nxt;
  end

  // With fill, a full negative number is one cell wider than the field and starts left of it.
  assign nchar  = N_W'(q_desc.ndig) + N_W'(q_desc.neg);
  assign offset = 14'(CELL_WIDTH * MAX_DIGITS) - 14'(nchar) * 14'(CELL_WIDTH);

  assign glyph   = minus_r ? MINUS_GLYPH : digits_r[pos_r];
  assign is_last = ~minus_r & (pos_r == '0);

  always_comb begin
    active_nxt = active_r;
    minus_nxt  = minus_r;
    pos_nxt    = pos_r;
    digits_nxt = digits_r;
    dx_nxt     = dx_r;
    y_nxt      = y_r;
    ovalid_nxt = 1'b0;
    odata_nxt  = odata_r;
    q_pop      = 1'b0;

    if (active_r) begin
      ovalid_nxt              = 1'b1;
      odata_nxt.glyph         = glyph;
      odata_nxt.src_x         = 7'(glyph * CELL_WIDTH);
      odata_nxt.dest_x        = dx_r;
      odata_nxt.dest_y        = y_r;
      odata_nxt.dest_y_bottom = 13'(y_r) + 13'(glyph_height) - 13'd1;
      odata_nxt.xor_mode      = (colour_planes > XOR_PLANES_MIN);
      odata_nxt.last          = is_last;
      dx_nxt = dx_r + 14'(CELL_WIDTH);
      if (minus_r) begin
        minus_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end else if (!q_empty) begin
      q_pop      = 1'b1;
      active_nxt = 1'b1;
      minus_nxt  = q_desc.neg;
      pos_nxt    = POS_W'(q_desc.ndig - 1'b1);
      digits_nxt = q_desc.digits;
      y_nxt      = q_desc.y_pos;
      dx_nxt     = {2'b00, q_desc.x_pos} + (q_desc.fill ? offset : 14'd0);
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

@@ sv/decimal_digit_glyph_placer.sv @@
// Top level of the decimal digit glyph placer: configuration registers, converter,
// descriptor queue and record emitter. Depends on dgp_pkg, dgp_front, dgp_queue, dgp_back.
//
//   channel   ports                          handshake
//   request   start, busy, in_data           taken when start & !busy
//   record    out_valid, out_data            valid for a single cycle, no backpressure
//   config    cfg_we, cfg_idx, cfg_wdata     written when cfg_we
//
// A request is clamped, then converted in the divide-by-ten unit one digit at a time,
// 1 to 7 digits in all, and then handed to the queue.
// The converter holds in its hand-off cycle, busy high, while the queue is full.
// The emitter loads a descriptor, then sends one record per cycle, up to eight, and takes
// no new descriptor until the last is sent; the two-entry queue lets converter and emitter run at once.
// Reset is synchronous and empties the converter, queue and emitter.
module decimal_digit_glyph_placer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dgp_pkg::dgp_in_t  in_data,
  output logic              out_valid,
  output dgp_pkg::dgp_out_t out_data,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [5:0]        cfg_wdata
);
  import dgp_pkg::*;

  logic [5:0] glyph_height_r, glyph_height_nxt;
  logic [5:0] colour_planes_r, colour_planes_nxt;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  dgp_desc_t  wr_desc;
  dgp_desc_t  rd_desc;

  always_comb begin
    glyph_height_nxt  = glyph_height_r;
    colour_planes_nxt = colour_planes_r;
    if (cfg_we) begin
      case (dgp_cfg_idx_t'(cfg_idx))
        CFG_GLYPH_HEIGHT:  glyph_height_nxt  = cfg_wdata;
        CFG_COLOUR_PLANES: colour_planes_nxt = cfg_wdata;
        default: begin
          glyph_height_nxt = glyph_height_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_height_r  <= GLYPH_HEIGHT_RST;
      colour_planes_r <= COLOUR_PLANES_RST;
    end else begin
      glyph_height_r  <= glyph_height_nxt;
      colour_planes_r <= colour_planes_nxt;
    end
  end

  dgp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_desc  (wr_desc)
  );

  dgp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_desc (wr_desc),
    .pop     (q_pop),
    .rd_desc (rd_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  dgp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_desc        (rd_desc),
    .q_pop         (q_pop),
    .glyph_height  (glyph_height_r),
    .colour_planes (colour_planes_r),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  // The records of one number leave in consecutive cycles.
  a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("record burst broken before its last record");

  // A minus sign is always followed by at least one digit.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.glyph == MINUS_GLYPH |-> !out_data.last)
    else $error("minus glyph marked last");

  // The converter never hands over a descriptor the queue cannot hold.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  // Emitted glyphs are digits or the minus sign.
  a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.glyph <= MINUS_GLYPH)
    else $error("glyph index out of range");

endmodule

@@ bench/tb_top.sv @@
// Testbench for decimal_digit_glyph_placer: drives number requests and register writes,
// predicts every glyph record and checks each one as it leaves the block.
// Depends on dgp_pkg and the decimal_digit_glyph_placer RTL.
module tb_top;
  import dgp_pkg::*;

  localparam int unsigned FIELD_MAX = 9_999_999;

  // Keeps its own copy of the display registers and the records still owed.
  class glyph_run_checker;
    logic [5:0] cell_rows   = GLYPH_HEIGHT_RST;
    logic [5:0] plane_count = COLOUR_PLANES_RST;
    dgp_out_t   pending_glyphs[$];
    int         errors   = 0;
    int         requests = 0;
    int         records  = 0;

    function void write_reg(dgp_cfg_idx_t idx, logic [5:0] data);
      if (idx == CFG_GLYPH_HEIGHT) begin
        cell_rows = data;
      end else begin
        plane_count = data;
      end
    endfunction

    // Builds the whole run of records for one accepted number.
    function void take_request(dgp_in_t req);
      logic [31:0] mag;
      logic        neg;
      logic [3:0]  chars[$];
      int          dx;
      logic [12:0] bottom;
      dgp_out_t    rec;
      requests++;
      neg = req.value[31];
      mag = neg ? (~req.value + 32'd1) : req.value;
      if (mag > FIELD_MAX) begin
        mag = 0;
        neg = 1'b0;
      end
      do begin
        chars.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (neg) chars.push_front(MINUS_GLYPH);
      dx = int'(req.x_pos);
      if (req.fill) dx += CELL_WIDTH * (MAX_DIGITS - chars.size());
      bottom = 13'(req.y_pos) + 13'(cell_rows) - 13'd1;
      for (int k = 0; k < chars.size(); k++) begin
        rec.glyph         = chars[k];
        rec.src_x         = 7'(chars[k] * CELL_WIDTH);
        rec.dest_x        = dx[13:0];
        rec.dest_y        = req.y_pos;
        rec.dest_y_bottom = bottom;
        rec.xor_mode      = plane_count > XOR_PLANES_MIN;
        rec.last          = (k == chars.size() - 1);
        pending_glyphs.push_back(rec);
        dx += CELL_WIDTH;
      end
    endfunction

    function void report(string field, int want, int got);
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_glyph(dgp_out_t got);
      dgp_out_t want;
      records++;
      if (pending_glyphs.size() == 0) begin
        $display("%0t: unexpected record, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = pending_glyphs.pop_front();
      if (got.glyph !== want.glyph) report("glyph", want.glyph, got.glyph);
      if (got.src_x !== want.src_x) report("src_x", want.src_x, got.src_x);
      if (got.dest_x !== want.dest_x) report("dest_x", want.dest_x, got.dest_x);
      if (got.dest_y !== want.dest_y) report("dest_y", want.dest_y, got.dest_y);
      if (got.dest_y_bottom !== want.dest_y_bottom)
        report("dest_y_bottom", want.dest_y_bottom, got.dest_y_bottom);
      if (got.xor_mode !== want.xor_mode) report("xor_mode", want.xor_mode, got.xor_mode);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         start;
  logic         busy;
  dgp_in_t      in_data;
  logic         out_valid;
  dgp_out_t     out_data;
  logic         cfg_we;
  dgp_cfg_idx_t cfg_idx;
  logic [5:0]   cfg_wdata;

  glyph_run_checker board = new();

  decimal_digit_glyph_placer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // All three channels are observed at the clock edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_idx, cfg_wdata);
      if (start && !busy) board.take_request(in_data);
      if (out_valid) board.check_glyph(out_data);
    end
  end

  function automatic dgp_in_t make_req(logic [31:0] value, int x, int y, logic fill);
    dgp_in_t req;
    req.value = value;
    req.x_pos = 12'(x);
    req.y_pos = 12'(y);
    req.fill  = fill;
    return req;
  endfunction

  // Mostly in-range numbers of a random digit count, some boundary and raw 32-bit values.
  function automatic logic [31:0] pick_value();
    int          nd;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 20) return $urandom();
    if (sel < 28) begin
      mag = $urandom_range(1, 0) ? FIELD_MAX : FIELD_MAX + 1;
    end else begin
      nd  = $urandom_range(MAX_DIGITS, 1);
      hi  = 10 ** nd - 1;
      lo  = (nd == 1) ? 0 : 10 ** (nd - 1);
      mag = $urandom_range(hi, lo);
    end
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  task automatic send_request(dgp_in_t req, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (board.pending_glyphs.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
    if (board.pending_glyphs.size() != 0) begin
      $display("%0t: %0d records expected but never seen", $time,
               board.pending_glyphs.size());
      board.errors++;
    end
  endtask

  task automatic set_display(logic [5:0] rows, logic [5:0] planes);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GLYPH_HEIGHT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_idx   <= CFG_COLOUR_PLANES;
    cfg_wdata <= planes;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    dgp_in_t    directed[$];
    int         phase_rows[5]   = '{0, 63, 1, 27, 45};
    int         phase_planes[5] = '{10, 9, 63, 0, 32};
    int         phase_idle[5]   = '{62, 0, 33, 62, 0};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_GLYPH_HEIGHT;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, single digits, the field limits, clamped values and a minus that
    // pushes the first cell left of x_pos.
    directed.push_back(make_req(32'd0, 100, 50, 1'b0));
    directed.push_back(make_req(32'd0, 100, 50, 1'b1));
    directed.push_back(make_req(32'd1, 0, 0, 1'b1));
    directed.push_back(make_req(-32'sd1, 0, 0, 1'b1));
    directed.push_back(make_req(32'd9999999, 4095, 4095, 1'b0));
    directed.push_back(make_req(-32'sd9999999, 0, 0, 1'b1));
    directed.push_back(make_req(-32'sd9999999, 4095, 4095, 1'b0));
    directed.push_back(make_req(32'd10000000, 10, 10, 1'b1));
    directed.push_back(make_req(-32'sd10000000, 10, 10, 1'b0));
    directed.push_back(make_req(32'h7FFF_FFFF, 2048, 2048, 1'b1));
    directed.push_back(make_req(32'h8000_0000, 2047, 2047, 1'b1));
    directed.push_back(make_req(32'd1234567, 300, 200, 1'b1));
    directed.push_back(make_req(-32'sd890, 7, 9, 1'b1));
    directed.push_back(make_req(32'd9876543, 4095, 1, 1'b1));
    directed.push_back(make_req(-32'sd1234567, 4095, 4095, 1'b1));
    directed.push_back(make_req(32'd5, 4095, 0, 1'b1));
    directed.push_back(make_req(32'd42, 1365, 2730, 1'b0));
    foreach (directed[i]) send_request(directed[i], 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      set_display(6'(phase_rows[p]), 6'(phase_planes[p]));
      if (p == 0) begin
        // Zero glyph height: the bottom row wraps below the top.
        send_request(make_req(32'd5, 12, 0, 1'b0), 0);
        send_request(make_req(-32'sd42, 4095, 4095, 1'b1), 0);
      end
      for (int i = 0; i < 26; i++)
        send_request(make_req(pick_value(), $urandom_range(4095), $urandom_range(4095),
                              1'($urandom_range(1))), phase_idle[p]);
      drain();
    end

    $display("Covered %0d number requests and %0d glyph records over six register settings.",
             board.requests, board.records);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out waiting for the block.");
    $display("Some tests failed");
    $finish;
  end

endmodule
